[design/dhbm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhbm_pkg
// Shared types, codes and helper functions of the d-pad hat-to-button mapper.
// ----------------------------------------------------------------------------
package dhbm_pkg;

    localparam int DIR_W   = 4;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;
    localparam int DELAY_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = DELAY_W;

    // Depth of the event list (one item yields at most four events), and its count width
    localparam int MAX_EVENTS = 6;
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);

    typedef logic [DIR_W-1:0]   dir_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [DELAY_W-1:0] delay_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // Event kinds
    localparam kind_t EV_RELEASE  = 2'd0;
    localparam kind_t EV_PRESS    = 2'd1;
    localparam kind_t EV_ACTIVE   = 2'd2;
    localparam kind_t EV_RELEASED = 2'd3;

    // Modes
    localparam mode_t MODE_STANDARD  = 2'd0;
    localparam mode_t MODE_EIGHT_WAY = 2'd1;
    localparam mode_t MODE_FOUR_CARD = 2'd2;
    localparam mode_t MODE_FOUR_DIAG = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd1;

    // Direction codes
    localparam dir_t DIR_CENTER = 4'd0;
    localparam dir_t DIR_UP     = 4'd1;
    localparam dir_t DIR_RIGHT  = 4'd2;
    localparam dir_t DIR_DOWN   = 4'd4;
    localparam dir_t DIR_LEFT   = 4'd8;
    localparam dir_t DIR_UR     = 4'd3;
    localparam dir_t DIR_DR     = 4'd6;
    localparam dir_t DIR_DL     = 4'd12;
    localparam dir_t DIR_UL     = 4'd9;

    function automatic logic is_diag(input dir_t d);
        return (d == DIR_UR) || (d == DIR_DR) || (d == DIR_UL) || (d == DIR_DL);
    endfunction

    function automatic logic is_valid_dir(input dir_t d);
        return (d == DIR_CENTER) || (d == DIR_UP) || (d == DIR_RIGHT) ||
               (d == DIR_DOWN) || (d == DIR_LEFT) || is_diag(d);
    endfunction

    // Fold a direction onto one cardinal button
    function automatic dir_t fold_card(input dir_t d);
        dir_t r;
        case (d)
            DIR_UP, DIR_UR:    r = DIR_UP;
            DIR_DOWN, DIR_DL:  r = DIR_DOWN;
            DIR_LEFT, DIR_UL:  r = DIR_LEFT;
            DIR_RIGHT, DIR_DR: r = DIR_RIGHT;
            default:           r = DIR_CENTER;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[design/dpad_hat_to_button_mapper_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpad_hat_to_button_mapper_unit
// Turns hat samples and millisecond ticks into button press/release events.
// ----------------------------------------------------------------------------
// An accepted item lands in an input register and is processed as soon as
// the result buffer is empty or is on its final transfer; its events (zero
// to four) are then sent one per cycle while m_ready is high, on the result
// channel, with m_last on the final one. A new item can wait in the input
// register meanwhile, so the result buffer draining sets the sustained rate.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must do so while the unit is idle (not enforced); unknown indexes are ignored.
module dpad_hat_to_button_mapper_unit (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          cfg_we,
    input  wire [dhbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [dhbm_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_req_type,
    input  wire [dhbm_pkg::DIR_W-1:0]    s_direction,
    input  wire                          s_bypass_delay,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [dhbm_pkg::KIND_W-1:0]  m_event_kind,
    output logic [dhbm_pkg::DIR_W-1:0]   m_button_code,
    output logic                         m_last
);
    import dhbm_pkg::*;

    // Configuration
    mode_t  mode_reg;
    delay_t delay_reg;

    // Input register
    logic   in_valid_reg;
    logic   in_tick_reg;
    dir_t   in_dir_reg;
    logic   in_bypass_reg;

    // Mapper state
    dir_t   pending_reg, pending_next;
    dir_t   applied_reg, applied_next;
    logic   diag_active_reg, diag_active_next;
    dir_t   diag_code_reg, diag_code_next;
    logic   timer_run_reg, timer_run_next;
    delay_t timer_left_reg, timer_left_next;

    // Result buffer, entry 0 is at the head
    kind_t  buf_kind_reg [MAX_EVENTS];
    dir_t   buf_code_reg [MAX_EVENTS];
    cnt_t   buf_cnt_reg;

    kind_t  ev_kind [MAX_EVENTS];
    dir_t   ev_code [MAX_EVENTS];
    cnt_t   ev_cnt;

    logic   out_xfer;
    logic   buf_free;
    logic   proc_fire;

    assign out_xfer  = m_valid && m_ready;
    assign buf_free  = (buf_cnt_reg == '0) || ((buf_cnt_reg == cnt_t'(1)) && m_ready);
    assign proc_fire = in_valid_reg && buf_free;
    assign s_ready   = !in_valid_reg || proc_fire;

    assign m_valid       = (buf_cnt_reg != '0);
    assign m_event_kind  = buf_kind_reg[0];
    assign m_button_code = buf_code_reg[0];
    assign m_last        = (buf_cnt_reg == cnt_t'(1));

    // Event list and next state for the item in the input register
    always_comb begin
        dir_t   val;
        dir_t   prev;
        dir_t   fp;
        dir_t   fv;
        delay_t left_dec;
        logic   now;
        logic   do_apply;
        logic   diag_rel;

        pending_next     = pending_reg;
        applied_next     = applied_reg;
        diag_active_next = diag_active_reg;
        diag_code_next   = diag_code_reg;
        timer_run_next   = timer_run_reg;
        timer_left_next  = timer_left_reg;
        do_apply         = 1'b0;
        diag_rel         = 1'b0;
        ev_cnt           = '0;
        for (int i = 0; i < MAX_EVENTS; i++) begin
            ev_kind[i] = EV_RELEASE;
            ev_code[i] = DIR_CENTER;
        end

        val      = is_valid_dir(in_dir_reg) ? in_dir_reg : DIR_CENTER;
        now      = in_bypass_reg || (delay_reg == '0);
        left_dec = (timer_left_reg != '0) ? timer_left_reg - delay_t'(1) : '0;

        if (in_tick_reg) begin
            if (timer_run_reg) begin
                timer_left_next = left_dec;
                if (left_dec == '0) begin
                    timer_run_next = 1'b0;
                    do_apply       = 1'b1;
                end
            end
        end else if (val != pending_reg) begin
            pending_next = val;
            if (val != DIR_CENTER) begin
                if (applied_reg == DIR_CENTER) begin
                    ev_kind[ev_cnt] = EV_ACTIVE;
                    ev_code[ev_cnt] = val;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
                if (now) begin
                    timer_run_next  = 1'b0;
                    timer_left_next = '0;
                    do_apply        = 1'b1;
                end else if (val != applied_reg) begin
                    if (!timer_run_reg) begin
                        timer_run_next  = 1'b1;
                        timer_left_next = delay_reg;
                    end
                end else begin
                    timer_run_next  = 1'b0;
                    timer_left_next = '0;
                end
            end else begin
                ev_kind[ev_cnt] = EV_RELEASED;
                ev_code[ev_cnt] = DIR_CENTER;
                ev_cnt          = ev_cnt + cnt_t'(1);
                if (now) begin
                    timer_run_next  = 1'b0;
                    timer_left_next = '0;
                    do_apply        = 1'b1;
                end else if (!timer_run_reg) begin
                    timer_run_next  = 1'b1;
                    timer_left_next = delay_reg;
                end
            end
        end

        // Apply the pending direction to the buttons: releases, then presses
        prev = applied_reg;
        val  = pending_next;
        fp   = fold_card(prev);
        fv   = fold_card(val);
        if (do_apply && (val != prev)) begin
            if (diag_active_reg) begin
                ev_kind[ev_cnt]  = EV_RELEASE;
                ev_code[ev_cnt]  = diag_code_reg;
                ev_cnt           = ev_cnt + cnt_t'(1);
                diag_active_next = 1'b0;
                diag_code_next   = DIR_CENTER;
                diag_rel         = 1'b1;
            end else if (mode_reg == MODE_STANDARD) begin
                if (prev[0] && !val[0]) begin
                    ev_kind[ev_cnt] = EV_RELEASE;
                    ev_code[ev_cnt] = DIR_UP;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
                if (prev[2] && !val[2]) begin
                    ev_kind[ev_cnt] = EV_RELEASE;
                    ev_code[ev_cnt] = DIR_DOWN;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
                if (prev[3] && !val[3]) begin
                    ev_kind[ev_cnt] = EV_RELEASE;
                    ev_code[ev_cnt] = DIR_LEFT;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
                if (prev[1] && !val[1]) begin
                    ev_kind[ev_cnt] = EV_RELEASE;
                    ev_code[ev_cnt] = DIR_RIGHT;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
            end else if (mode_reg == MODE_FOUR_CARD) begin
                if ((fp != DIR_CENTER) && (fp != fv)) begin
                    ev_kind[ev_cnt] = EV_RELEASE;
                    ev_code[ev_cnt] = fp;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
            end else if (prev != DIR_CENTER) begin
                ev_kind[ev_cnt] = EV_RELEASE;
                ev_code[ev_cnt] = prev;
                ev_cnt          = ev_cnt + cnt_t'(1);
            end

            if (mode_reg == MODE_STANDARD) begin
                if (val[0] && !prev[0]) begin
                    ev_kind[ev_cnt] = EV_PRESS;
                    ev_code[ev_cnt] = DIR_UP;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
                if (val[2] && !prev[2]) begin
                    ev_kind[ev_cnt] = EV_PRESS;
                    ev_code[ev_cnt] = DIR_DOWN;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
                if (val[3] && !prev[3]) begin
                    ev_kind[ev_cnt] = EV_PRESS;
                    ev_code[ev_cnt] = DIR_LEFT;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
                if (val[1] && !prev[1]) begin
                    ev_kind[ev_cnt] = EV_PRESS;
                    ev_code[ev_cnt] = DIR_RIGHT;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
            end else if (mode_reg == MODE_FOUR_CARD) begin
                // Skip the press when the folded button is already held
                if ((fv != DIR_CENTER) && (diag_rel || (fv != fp))) begin
                    ev_kind[ev_cnt] = EV_PRESS;
                    ev_code[ev_cnt] = fv;
                    ev_cnt          = ev_cnt + cnt_t'(1);
                end
            end else if (is_diag(val)) begin
                diag_active_next = 1'b1;
                diag_code_next   = val;
                ev_kind[ev_cnt]  = EV_PRESS;
                ev_code[ev_cnt]  = val;
                ev_cnt           = ev_cnt + cnt_t'(1);
            end else if ((mode_reg == MODE_EIGHT_WAY) && (val != DIR_CENTER)) begin
                ev_kind[ev_cnt] = EV_PRESS;
                ev_code[ev_cnt] = val;
                ev_cnt          = ev_cnt + cnt_t'(1);
            end

            applied_next = val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_STANDARD;
            delay_reg       <= '0;
            in_valid_reg    <= 1'b0;
            pending_reg     <= DIR_CENTER;
            applied_reg     <= DIR_CENTER;
            diag_active_reg <= 1'b0;
            diag_code_reg   <= DIR_CENTER;
            timer_run_reg   <= 1'b0;
            timer_left_reg  <= '0;
            buf_cnt_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MODE:  mode_reg  <= cfg_wdata[MODE_W-1:0];
                    REG_DELAY: delay_reg <= cfg_wdata[DELAY_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire) begin
                pending_reg     <= pending_next;
                applied_reg     <= applied_next;
                diag_active_reg <= diag_active_next;
                diag_code_reg   <= diag_code_next;
                timer_run_reg   <= timer_run_next;
                timer_left_reg  <= timer_left_next;
                buf_cnt_reg     <= ev_cnt;
            end else if (out_xfer) begin
                buf_cnt_reg <= buf_cnt_reg - cnt_t'(1);
            end
        end
    end

    // Payload registers: capture on transfer, load or advance the buffer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_tick_reg   <= s_req_type;
            in_dir_reg    <= s_direction;
            in_bypass_reg <= s_bypass_delay;
        end
        if (proc_fire) begin
            for (int i = 0; i < MAX_EVENTS; i++) begin
                buf_kind_reg[i] <= ev_kind[i];
                buf_code_reg[i] <= ev_code[i];
            end
        end else if (out_xfer) begin
            for (int i = 0; i < MAX_EVENTS - 1; i++) begin
                buf_kind_reg[i] <= buf_kind_reg[i+1];
                buf_code_reg[i] <= buf_code_reg[i+1];
            end
        end
    end

endmodule
`default_nettype wire

[sim/dpad_hat_to_button_mapper_unit_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpad_hat_to_button_mapper_unit_tb
// Self-checking bench for the hat-to-button mapper.
// ----------------------------------------------------------------------------
// A short directed table walks each mode, the opposite-bit and idle-tick
// cases, the settle timer and an unused register index. Random phases
// follow, each with its own mode and delay. One phase loads the longest
// delay, so its countdown starts, holds through ticks and drops on bypass or
// when the hat returns. Every accepted item runs through a local model of
// the mapper, and the expected button events are queued and compared in
// order with what the unit sends. Both channels get random gaps. In one
// phase the result side also holds off for a long stretch, so the unit
// fills up and backs up its input.
// ----------------------------------------------------------------------------
module dpad_hat_to_button_mapper_unit_tb;
    import dhbm_pkg::*;

    localparam bit REQ_SAMPLE = 1'b0;
    localparam bit REQ_TICK   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam delay_t DELAY_MAX = 10'd1000;
    localparam int LONG_HOLD = 60;
    localparam int PHASE_ITEMS = 24;
    localparam int unsigned RUN_LIMIT = 400_000;

    // Order in which standard mode scans the cardinal buttons
    localparam logic [3:0][DIR_W-1:0] BUTTON_SCAN = {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};

    typedef struct packed {
        kind_t kind;
        dir_t  code;
        logic  last;
    } button_event_t;

    typedef struct packed {
        bit                     is_cfg;
        bit                     tick;
        dir_t                   dir;
        bit                     byp;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  wdata;
        bit                     typed;
        logic [1:0]             n_typed;
        button_event_t [2:0]    want;
    } plan_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic [DIR_W-1:0] s_direction = '0;
    logic s_bypass_delay = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [KIND_W-1:0] m_event_kind;
    logic [DIR_W-1:0] m_button_code;
    logic m_last;

    // Mapper model state and configuration
    mode_t  cur_mode = MODE_STANDARD;
    delay_t cur_delay = '0;
    dir_t   hat_pending = DIR_CENTER;
    dir_t   hat_applied = DIR_CENTER;
    bit     diag_held = 1'b0;
    dir_t   diag_button = DIR_CENTER;
    bit     settle_running = 1'b0;
    delay_t settle_left = '0;

    button_event_t step_events[$];
    button_event_t events_due[$];

    bit calm = 1'b0;
    bit stall_burst_req = 1'b0;
    int fail_count = 0;
    int items_sent = 0;
    int items_moved = 0;
    int ticks_sent = 0;
    int events_seen = 0;
    int cfg_writes = 0;
    int unsigned cycle_count = 0;

    dpad_hat_to_button_mapper_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_direction    (s_direction),
        .s_bypass_delay (s_bypass_delay),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_button_code  (m_button_code),
        .m_last         (m_last)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Mapper model
    // ------------------------------------------------------------------
    function automatic dir_t rot_cw(input dir_t c);
        return {c[2:0], c[3]};
    endfunction

    // Cardinal a direction folds onto: a diagonal folds onto its first bit
    // going clockwise; opposite-bit patterns give center
    function automatic dir_t card_of(input dir_t d);
        dir_t c;
        dir_t hit;
        hit = DIR_CENTER;
        c = DIR_UP;
        repeat (4) begin
            if (d == c || d == (c | rot_cw(c))) hit = c;
            c = rot_cw(c);
        end
        return hit;
    endfunction

    function automatic bit two_bits(input dir_t d);
        return card_of(d) != DIR_CENTER && d != card_of(d);
    endfunction

    function automatic void note(input kind_t k, input dir_t c);
        step_events.push_back({k, c, 1'b0});
    endfunction

    function automatic void settle_buttons();
        dir_t was;
        dir_t now_dir;
        dir_t b;
        dir_t f;
        bit diag_dropped;
        was = hat_applied;
        now_dir = hat_pending;
        diag_dropped = 1'b0;
        if (now_dir != was) begin
            // Release what is no longer wanted
            if (diag_held) begin
                note(EV_RELEASE, diag_button);
                diag_held = 1'b0;
                diag_button = DIR_CENTER;
                diag_dropped = 1'b1;
            end else if (cur_mode == MODE_STANDARD) begin
                for (int i = 0; i < 4; i++) begin
                    b = BUTTON_SCAN[i];
                    if ((was & b) != 0 && (now_dir & b) == 0) note(EV_RELEASE, b);
                end
            end else if (cur_mode == MODE_FOUR_CARD) begin
                f = card_of(was);
                if (f != DIR_CENTER && f != card_of(now_dir)) note(EV_RELEASE, f);
            end else if (was != DIR_CENTER) begin
                note(EV_RELEASE, was);
            end
            // Press the new ones
            if (cur_mode == MODE_STANDARD) begin
                for (int i = 0; i < 4; i++) begin
                    b = BUTTON_SCAN[i];
                    if ((now_dir & b) != 0 && (was & b) == 0) note(EV_PRESS, b);
                end
            end else if (cur_mode == MODE_FOUR_CARD) begin
                f = card_of(now_dir);
                if (f != DIR_CENTER && (diag_dropped || f != card_of(was))) note(EV_PRESS, f);
            end else if (two_bits(now_dir)) begin
                diag_held = 1'b1;
                diag_button = now_dir;
                note(EV_PRESS, now_dir);
            end else if (cur_mode == MODE_EIGHT_WAY && now_dir != DIR_CENTER) begin
                note(EV_PRESS, now_dir);
            end
            hat_applied = now_dir;
        end
    endfunction

    // Advance the model by one item; report whether it did anything
    function automatic bit hat_step(input bit is_tick, input dir_t raw, input bit byp);
        dir_t v;
        bit at_once;
        bit moved;
        button_event_t tail;
        step_events.delete();
        moved = 1'b0;
        at_once = byp || cur_delay == 0;
        v = (raw == DIR_CENTER || card_of(raw) != DIR_CENTER) ? raw : DIR_CENTER;
        if (is_tick) begin
            if (settle_running) begin
                moved = 1'b1;
                if (settle_left != 0) settle_left = settle_left - 1'b1;
                if (settle_left == 0) begin
                    settle_running = 1'b0;
                    settle_buttons();
                end
            end
        end else if (v != hat_pending) begin
            moved = 1'b1;
            if (v != DIR_CENTER) begin
                if (hat_applied == DIR_CENTER) note(EV_ACTIVE, v);
                hat_pending = v;
                if (at_once) begin
                    settle_running = 1'b0;
                    settle_left = '0;
                    settle_buttons();
                end else if (hat_pending != hat_applied) begin
                    if (!settle_running) begin
                        settle_running = 1'b1;
                        settle_left = cur_delay;
                    end
                end else begin
                    // back to what is applied: drop the countdown
                    settle_running = 1'b0;
                    settle_left = '0;
                end
            end else begin
                note(EV_RELEASED, DIR_CENTER);
                hat_pending = DIR_CENTER;
                if (at_once) begin
                    settle_running = 1'b0;
                    settle_left = '0;
                    settle_buttons();
                end else if (!settle_running) begin
                    settle_running = 1'b1;
                    settle_left = cur_delay;
                end
            end
        end
        if (step_events.size() != 0) begin
            tail = step_events.pop_back();
            tail.last = 1'b1;
            step_events.push_back(tail);
        end
        return moved;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic dir_t pick_hat();
        case ($urandom_range(0, 9))
            0: return DIR_CENTER;
            1: return DIR_UP;
            2: return DIR_RIGHT;
            3: return DIR_DOWN;
            4: return DIR_LEFT;
            5: return DIR_UR;
            6: return DIR_DR;
            7: return DIR_DL;
            8: return DIR_UL;
            default: return dir_t'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic button_event_t ev(input kind_t k, input dir_t c);
        return {k, c, 1'b0};
    endfunction

    function automatic plan_row_t item_row(input bit is_tick, input dir_t d, input bit b);
        plan_row_t r;
        r = '0;
        r.tick = is_tick;
        r.dir = d;
        r.byp = b;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input bit is_tick, input dir_t d, input bit b,
                                           input int n, input button_event_t e0,
                                           input button_event_t e1, input button_event_t e2);
        plan_row_t r;
        r = item_row(is_tick, d, b);
        r.typed = 1'b1;
        r.n_typed = n[1:0];
        r.want[0] = e0;
        r.want[1] = e1;
        r.want[2] = e2;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.wdata = data;
        return r;
    endfunction

    task automatic send_item(input bit is_tick, input dir_t d, input bit byp,
                             input bit predicted);
        int gap;
        bit moved;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= is_tick;
        s_direction <= d;
        s_bypass_delay <= byp;
        do @(posedge aclk); while (!s_ready);
        moved = hat_step(is_tick, d, byp);
        if (predicted) begin
            foreach (step_events[i]) events_due.push_back(step_events[i]);
        end
        items_sent++;
        if (moved) items_moved++;
        if (is_tick) ticks_sent++;
    endtask

    // Drain every expected event, then give a silent last item time to finish
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == REG_MODE) cur_mode = mode_t'(data[MODE_W-1:0]);
        else if (idx == REG_DELAY) cur_delay = data;
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int n;
        forever begin
            @(posedge aclk);
            if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_events
        button_event_t got;
        button_event_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_event_kind, m_button_code, m_last};
            events_seen++;
            if (events_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected event kind=%0d code=%0d last=%0d",
                         $time, got.kind, got.code, got.last);
            end else begin
                want = events_due.pop_front();
                if (got.kind !== want.kind || got.code !== want.code ||
                    got.last !== want.last) begin
                    fail_count++;
                    $display("%0t: event mismatch: expected kind=%0d code=%0d last=%0d, got kind=%0d code=%0d last=%0d",
                             $time, want.kind, want.code, want.last,
                             got.kind, got.code, got.last);
                end
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        plan_row_t plan[$];
        plan_row_t row;
        button_event_t e;
        mode_t m;
        delay_t dl;
        bit is_tick;
        bit phase_calm;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: standard mode, no delay
        plan.push_back(typed_row(REQ_SAMPLE, DIR_UP, 1'b0, 2, ev(EV_ACTIVE, DIR_UP),
                                 ev(EV_PRESS, DIR_UP), ev(EV_RELEASE, DIR_CENTER)));
        plan.push_back(item_row(REQ_SAMPLE, DIR_UP, 1'b0));
        plan.push_back(item_row(REQ_SAMPLE, DIR_UR, 1'b0));
        // up and down together count as centered
        plan.push_back(typed_row(REQ_SAMPLE, DIR_UP | DIR_DOWN, 1'b0, 3,
                                 ev(EV_RELEASED, DIR_CENTER), ev(EV_RELEASE, DIR_UP),
                                 ev(EV_RELEASE, DIR_RIGHT)));
        plan.push_back(typed_row(REQ_TICK, DIR_UP | DIR_RIGHT | DIR_DOWN | DIR_LEFT, 1'b1, 0,
                                 ev(EV_RELEASE, DIR_CENTER), ev(EV_RELEASE, DIR_CENTER),
                                 ev(EV_RELEASE, DIR_CENTER)));
        plan.push_back(typed_row(REQ_SAMPLE, DIR_UP | DIR_RIGHT | DIR_DOWN | DIR_LEFT, 1'b0, 0,
                                 ev(EV_RELEASE, DIR_CENTER), ev(EV_RELEASE, DIR_CENTER),
                                 ev(EV_RELEASE, DIR_CENTER)));
        plan.push_back(item_row(REQ_SAMPLE, DIR_DL, 1'b1));
        plan.push_back(item_row(REQ_SAMPLE, DIR_CENTER, 1'b0));
        plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(MODE_EIGHT_WAY)));
        plan.push_back(item_row(REQ_SAMPLE, DIR_UL, 1'b0));
        plan.push_back(item_row(REQ_SAMPLE, DIR_LEFT, 1'b0));
        plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(MODE_FOUR_CARD)));
        plan.push_back(item_row(REQ_SAMPLE, DIR_UL, 1'b0));
        plan.push_back(item_row(REQ_SAMPLE, DIR_DR, 1'b0));
        plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(MODE_FOUR_DIAG)));
        plan.push_back(item_row(REQ_SAMPLE, DIR_UR, 1'b0));
        plan.push_back(item_row(REQ_SAMPLE, DIR_DOWN, 1'b0));
        plan.push_back(item_row(REQ_SAMPLE, DIR_CENTER, 1'b0));
        plan.push_back(cfg_row(REG_DELAY, DELAY_MAX));
        plan.push_back(item_row(REQ_SAMPLE, DIR_UP, 1'b1));
        plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(MODE_STANDARD)));
        plan.push_back(item_row(REQ_SAMPLE, DIR_RIGHT, 1'b0));
        plan.push_back(item_row(REQ_SAMPLE, DIR_UP, 1'b0));
        plan.push_back(cfg_row(REG_DELAY, 10'd2));
        plan.push_back(item_row(REQ_SAMPLE, DIR_DOWN, 1'b0));
        // new delay must not reload the running countdown
        plan.push_back(cfg_row(REG_DELAY, 10'd5));
        plan.push_back(item_row(REQ_TICK, DIR_CENTER, 1'b0));
        plan.push_back(item_row(REQ_TICK, DIR_LEFT, 1'b1));
        plan.push_back(cfg_row(REG_SPARE, 10'd1023));

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg) begin
                settle_idle();
                cfg_write(row.reg_idx, row.wdata);
            end else begin
                send_item(row.tick, row.dir, row.byp, !row.typed);
                if (row.typed) begin
                    for (int k = 0; k < row.n_typed; k++) begin
                        e = row.want[k];
                        e.last = (k == row.n_typed - 1);
                        events_due.push_back(e);
                    end
                end
            end
        end

        for (int p = 0; p < 8; p++) begin
            settle_idle();
            m = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(0, 3));
            case (p)
                0, 3, 6: dl = '0;
                1:       dl = 10'd1;
                2:       dl = DELAY_MAX;
                4:       dl = 10'd3;
                default: dl = delay_t'($urandom_range(1, 8));
            endcase
            cfg_write(REG_MODE, CFG_DATA_W'(m));
            cfg_write(REG_DELAY, dl);
            phase_calm = (p == 3);
            calm = phase_calm;
            // back up the result side while items keep coming
            if (p == 0) stall_burst_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                is_tick = ($urandom_range(0, 99) < 35);
                send_item(is_tick, pick_hat(), ($urandom_range(0, 3) == 0), 1'b1);
            end
        end

        s_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Sent %0d items (%0d ticks, %0d changed the mapper) and checked %0d events.",
                 items_sent, ticks_sent, items_moved, events_seen);
        $display("Made %0d register writes over all four modes, delays from 0 to 1000.",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
